// File: hw/rtl/mase_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mase_pkg
// Shared types, constants and helpers of the balance error block.
// ----------------------------------------------------------------------------
package mase_pkg;

    localparam int WINDOW_MAX  = 128;
    localparam int WIN_AW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W       = 33 + WIN_AW;
    localparam int DIFF_W      = SUM_W + 2;
    localparam int DIV_CW      = $clog2(SUM_W + 1);
    localparam int NUM_TARGETS = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int APB_AW      = 3;

    localparam logic [7:0] WINDOW_RESET = 8'd100;
    localparam logic       REG_WINDOW_SIZE = 1'b0;

    localparam logic [2:0] TGT_POSITION   = 3'd0;
    localparam logic [2:0] TGT_VELOCITY   = 3'd1;
    localparam logic [2:0] TGT_PITCH      = 3'd2;
    localparam logic [2:0] TGT_PITCH_RATE = 3'd3;
    localparam logic [2:0] TGT_YAW        = 3'd4;
    localparam logic [2:0] TGT_YAW_RATE   = 3'd5;

    localparam logic signed [31:0] HALF_PI_Q16 = 32'sd102944;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic [33:0]        ONE_Q28     = 34'd268435456;
    localparam logic [30:0]        ONE_Q30     = 31'd1073741824;
    localparam logic signed [63:0] ROUND_Q30   = 64'sd536870912;

    localparam logic signed [32:0] ASIN_COEF [8] = '{
        33'sd1686629690, -33'sd230423709, 33'sd95540460, -33'sd53874250,
        33'sd33169905, -33'sd18348235, 33'sd7161955, -33'sd1355590
    };

    typedef enum logic [1:0] {
        ACT_CMD  = 2'd0,
        ACT_IMU  = 2'd1,
        ACT_ODO  = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HMUL,
        ST_HADD,
        ST_SQRT,
        ST_PMUL,
        ST_PFIN,
        ST_ODO_RD,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_action            action;
        logic [2:0]         cmd_index;
        logic signed [31:0] cmd_value;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [31:0] pitch_rate;
        logic signed [31:0] position;
        logic signed [31:0] lin_vel;
        logic signed [31:0] yaw_vel;
    } t_item;

    typedef struct packed {
        logic signed [31:0] err_position;
        logic signed [31:0] err_velocity;
        logic signed [31:0] err_pitch;
        logic signed [31:0] err_pitch_rate;
        logic signed [31:0] err_yaw;
        logic signed [31:0] err_yaw_rate;
    } t_result;

    typedef struct packed {
        logic       wr;
        logic [7:0] size;
    } t_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [DIFF_W-1:0] v);
        logic same;
        same = (&v[DIFF_W-1:31]) | (~|v[DIFF_W-1:31]);
        if (same) begin
            return v[31:0];
        end
        return v[DIFF_W-1] ? 32'sh80000000 : 32'sh7fffffff;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mase_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mase_in_if / mase_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mase_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [2:0]         cmd_index;
    logic signed [31:0] cmd_value;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] pitch_rate;
    logic signed [31:0] position;
    logic signed [31:0] lin_vel;
    logic signed [31:0] yaw_vel;

    modport source(output valid, action, cmd_index, cmd_value, quat_w, quat_x, quat_y,
                   quat_z, pitch_rate, position, lin_vel, yaw_vel, input ready);
    modport sink(input valid, action, cmd_index, cmd_value, quat_w, quat_x, quat_y,
                 quat_z, pitch_rate, position, lin_vel, yaw_vel, output ready);
endinterface

interface mase_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] err_position;
    logic signed [31:0] err_velocity;
    logic signed [31:0] err_pitch;
    logic signed [31:0] err_pitch_rate;
    logic signed [31:0] err_yaw;
    logic signed [31:0] err_yaw_rate;

    modport source(output valid, err_position, err_velocity, err_pitch, err_pitch_rate,
                   err_yaw, err_yaw_rate, input ready);
    modport sink(input valid, err_position, err_velocity, err_pitch, err_pitch_rate,
                 err_yaw, err_yaw_rate, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mase_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mase_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mase_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: hw/rtl/mase_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mase_front
// Accepts input items, drops those without effect and queues the rest.
// ----------------------------------------------------------------------------
module mase_front import mase_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mase_in_if.sink   i_in,
    output logic      o_q_valid,
    output t_item     o_q_item,
    input  wire logic i_q_pop
);
    t_item                     w_item;
    t_item                     r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0]         r_wr_ptr;
    logic [QPTR_W-1:0]         r_rd_ptr;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] r_count;
    logic                      w_accept;
    logic                      w_keep;
    logic                      w_push;

    always_comb begin
        w_item.action     = t_action'(i_in.action);
        w_item.cmd_index  = i_in.cmd_index;
        w_item.cmd_value  = i_in.cmd_value;
        w_item.quat_w     = i_in.quat_w;
        w_item.quat_x     = i_in.quat_x;
        w_item.quat_y     = i_in.quat_y;
        w_item.quat_z     = i_in.quat_z;
        w_item.pitch_rate = i_in.pitch_rate;
        w_item.position   = i_in.position;
        w_item.lin_vel    = i_in.lin_vel;
        w_item.yaw_vel    = i_in.yaw_vel;
    end

    assign i_in.ready = (r_count != ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH));
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_keep     = (w_item.action != ACT_NONE) &&
                        !((w_item.action == ACT_CMD) && (w_item.cmd_index >= 3'(NUM_TARGETS)));
    assign w_push     = w_accept && w_keep;
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !i_q_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && i_q_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/mase_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mase_back
// Executes queued items: target writes, pitch arcsine, window averages.
// ----------------------------------------------------------------------------
module mase_back import mase_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_item i_q_item,
    output logic      o_q_pop,
    input  wire t_cfg i_cfg,
    mase_out_if.source o_out
);
    t_state                    r_state;
    t_state                    n_state;
    t_item                     r_item;
    logic signed [31:0]        r_targets [NUM_TARGETS];
    logic                      r_have_target;
    logic                      r_have_att;
    logic signed [31:0]        r_pitch;
    logic signed [31:0]        r_prate;
    logic signed [SUM_W-1:0]   r_vel_sum;
    logic signed [SUM_W-1:0]   r_yaw_sum;
    logic [CNT_W-1:0]          r_fill;
    logic [WIN_AW-1:0]         r_slot;
    logic [WIN_AW-1:0]         r_slotc;
    logic                      r_full;
    logic [29:0]               r_x30;
    logic signed [32:0]        r_p;
    logic signed [63:0]        r_prod;
    logic [2:0]                r_k;
    logic                      r_neg;
    logic [60:0]               r_sn;
    logic [60:0]               r_sr;
    logic [4:0]                r_j;
    logic [CNT_W-1:0]          r_div;
    logic [SUM_W-1:0]          r_vdq;
    logic [SUM_W-1:0]          r_ydq;
    logic [CNT_W-1:0]          r_vrem;
    logic [CNT_W-1:0]          r_yrem;
    logic                      r_vneg;
    logic                      r_yneg;
    logic [DIV_CW-1:0]         r_cnt;
    logic                      r_ovalid;
    t_result                   r_out;

    logic [CNT_W-1:0]          w_n;
    logic [WIN_AW-1:0]         w_slot;
    logic                      w_full;
    logic                      w_odo_ok;
    logic signed [33:0]        w_s;
    logic [33:0]               w_mag;
    logic signed [33:0]        w_mq;
    logic [61:0]               w_bit;
    logic [61:0]               w_sq_t;
    logic signed [34:0]        w_r30;
    logic [17:0]               w_q16;
    logic signed [31:0]        w_old_v;
    logic signed [31:0]        w_old_y;
    logic signed [SUM_W-1:0]   w_vsum_nx;
    logic signed [SUM_W-1:0]   w_ysum_nx;
    logic [CNT_W-1:0]          w_fill_nx;
    logic [CNT_W:0]            w_slot_inc;
    logic [CNT_W:0]            w_vt;
    logic [CNT_W:0]            w_yt;
    logic                      w_vge;
    logic                      w_yge;
    logic signed [DIFF_W-1:0]  w_vavg;
    logic signed [DIFF_W-1:0]  w_yavg;
    logic                      w_load;
    t_result                   w_res;
    logic                      w_ram_we;
    logic [63:0]               w_ram_rdata;

    mase_ram #(
        .WIDTH(64),
        .DEPTH(WINDOW_MAX)
    ) u_window (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(r_slotc),
        .i_wdata({r_item.yaw_vel, r_item.lin_vel}),
        .i_raddr(w_slot),
        .o_rdata(w_ram_rdata)
    );

    always_comb begin
        if (i_cfg.size == 8'd0) begin
            w_n = CNT_W'(1);
        end else if (int'(i_cfg.size) > WINDOW_MAX) begin
            w_n = CNT_W'(WINDOW_MAX);
        end else begin
            w_n = CNT_W'(i_cfg.size);
        end
    end

    assign w_slot   = (CNT_W'(r_slot) >= w_n) ? '0 : r_slot;
    assign w_full   = (r_fill >= w_n);
    assign w_odo_ok = r_have_target && r_have_att;

    assign w_s   = 34'(($signed(i_q_item.quat_w) * $signed(i_q_item.quat_y)
                      - $signed(i_q_item.quat_z) * $signed(i_q_item.quat_x))) <<< 1;
    assign w_mag = w_s[33] ? 34'(-w_s) : 34'(w_s);

    assign w_mq   = 34'((r_prod + ROUND_Q30) >>> 30);
    assign w_bit  = 62'(1) << {r_j, 1'b0};
    assign w_sq_t = 62'(r_sr) + w_bit;
    assign w_r30  = HALF_PI_Q30 - 35'(w_mq);
    assign w_q16  = w_r30[34] ? 18'd0 : 18'((w_r30 + 35'sd8192) >>> 14);

    assign w_old_v   = w_ram_rdata[31:0];
    assign w_old_y   = w_ram_rdata[63:32];
    assign w_vsum_nx = r_vel_sum - (r_full ? SUM_W'(w_old_v) : '0) + SUM_W'(r_item.lin_vel);
    assign w_ysum_nx = r_yaw_sum - (r_full ? SUM_W'(w_old_y) : '0) + SUM_W'(r_item.yaw_vel);
    assign w_fill_nx = r_full ? w_n : r_fill + 1'b1;
    assign w_slot_inc = (CNT_W+1)'(r_slotc) + 1'b1;

    assign w_vt  = {r_vrem, r_vdq[SUM_W-1]};
    assign w_yt  = {r_yrem, r_ydq[SUM_W-1]};
    assign w_vge = (w_vt >= {1'b0, r_div});
    assign w_yge = (w_yt >= {1'b0, r_div});

    assign w_vavg = r_vneg ? -$signed({2'b00, r_vdq}) : $signed({2'b00, r_vdq});
    assign w_yavg = r_yneg ? -$signed({2'b00, r_ydq}) : $signed({2'b00, r_ydq});

    always_comb begin
        w_res.err_position   = sat32(DIFF_W'(r_targets[TGT_POSITION]) - DIFF_W'(r_item.position));
        w_res.err_velocity   = sat32(DIFF_W'(r_targets[TGT_VELOCITY]) - w_vavg);
        w_res.err_pitch      = sat32(DIFF_W'(r_targets[TGT_PITCH]) - DIFF_W'(r_pitch));
        w_res.err_pitch_rate = sat32(DIFF_W'(r_targets[TGT_PITCH_RATE]) - DIFF_W'(r_prate));
        w_res.err_yaw        = r_targets[TGT_YAW];
        w_res.err_yaw_rate   = sat32(DIFF_W'(r_targets[TGT_YAW_RATE]) - w_yavg);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.action == ACT_IMU && w_mag < ONE_Q28) begin
                        n_state = ST_HMUL;
                    end else if (i_q_item.action == ACT_ODO && w_odo_ok) begin
                        n_state = ST_ODO_RD;
                    end
                end
            end
            ST_HMUL:   n_state = ST_HADD;
            ST_HADD:   n_state = (r_k == 3'd0) ? ST_SQRT : ST_HMUL;
            ST_SQRT:   n_state = (r_j == 5'd0) ? ST_PMUL : ST_SQRT;
            ST_PMUL:   n_state = ST_PFIN;
            ST_PFIN:   n_state = ST_IDLE;
            ST_ODO_RD: n_state = ST_DIV;
            ST_DIV:    n_state = (r_cnt == DIV_CW'(1)) ? ST_OUT : ST_DIV;
            ST_OUT:    n_state = w_load ? ST_IDLE : ST_OUT;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = 1'b0;
        w_ram_we = 1'b0;
        w_load   = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_q_pop  = i_q_valid;
            ST_ODO_RD: w_ram_we = 1'b1;
            ST_OUT:    w_load   = !r_ovalid || o_out.ready;
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_item  <= i_q_item;
                r_x30   <= 30'(w_mag) << 2;
                r_p     <= ASIN_COEF[7];
                r_k     <= 3'd6;
                r_neg   <= w_s[33];
                r_slotc <= w_slot;
                r_full  <= w_full;
            end
            ST_HMUL: begin
                r_prod <= r_p * $signed({1'b0, r_x30});
            end
            ST_HADD: begin
                r_p  <= ASIN_COEF[r_k] + w_mq[32:0];
                r_k  <= r_k - 1'b1;
                r_sn <= {61'(ONE_Q30 - 31'(r_x30))} << 30;
                r_sr <= '0;
                r_j  <= 5'd30;
            end
            ST_SQRT: begin
                if (62'(r_sn) >= w_sq_t) begin
                    r_sn <= 61'(62'(r_sn) - w_sq_t);
                    r_sr <= 61'((62'(r_sr) >> 1) + w_bit);
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_j <= r_j - 1'b1;
            end
            ST_PMUL: begin
                r_prod <= $signed({1'b0, r_sr[30:0]}) * r_p;
            end
            ST_ODO_RD: begin
                r_div  <= w_fill_nx;
                r_vneg <= w_vsum_nx[SUM_W-1];
                r_yneg <= w_ysum_nx[SUM_W-1];
                r_vdq  <= (w_vsum_nx[SUM_W-1] ? SUM_W'(-w_vsum_nx) : SUM_W'(w_vsum_nx))
                          + SUM_W'(w_fill_nx >> 1);
                r_ydq  <= (w_ysum_nx[SUM_W-1] ? SUM_W'(-w_ysum_nx) : SUM_W'(w_ysum_nx))
                          + SUM_W'(w_fill_nx >> 1);
                r_vrem <= '0;
                r_yrem <= '0;
                r_cnt  <= DIV_CW'(SUM_W);
            end
            ST_DIV: begin
                r_vrem <= w_vge ? CNT_W'(w_vt - {1'b0, r_div}) : CNT_W'(w_vt);
                r_yrem <= w_yge ? CNT_W'(w_yt - {1'b0, r_div}) : CNT_W'(w_yt);
                r_vdq  <= {r_vdq[SUM_W-2:0], w_vge};
                r_ydq  <= {r_ydq[SUM_W-2:0], w_yge};
                r_cnt  <= r_cnt - 1'b1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
        if (w_load) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_TARGETS; t++) begin
                r_targets[t] <= '0;
            end
            r_have_target <= 1'b0;
            r_have_att    <= 1'b0;
            r_pitch       <= '0;
            r_prate       <= '0;
            r_vel_sum     <= '0;
            r_yaw_sum     <= '0;
            r_fill        <= '0;
            r_slot        <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            if (r_state == ST_IDLE && i_q_valid) begin
                if (i_q_item.action == ACT_CMD) begin
                    r_targets[i_q_item.cmd_index] <= i_q_item.cmd_value;
                    r_have_target <= 1'b1;
                end else if (i_q_item.action == ACT_IMU) begin
                    r_prate <= i_q_item.pitch_rate;
                    if (w_mag >= ONE_Q28) begin
                        r_pitch    <= w_s[33] ? -HALF_PI_Q16 : HALF_PI_Q16;
                        r_have_att <= 1'b1;
                    end
                end
            end
            if (r_state == ST_PFIN) begin
                r_pitch    <= r_neg ? -$signed(32'(w_q16)) : $signed(32'(w_q16));
                r_have_att <= 1'b1;
            end
            if (i_cfg.wr) begin
                r_vel_sum <= '0;
                r_yaw_sum <= '0;
                r_fill    <= '0;
                r_slot    <= '0;
            end else if (r_state == ST_ODO_RD) begin
                r_vel_sum <= w_vsum_nx;
                r_yaw_sum <= w_ysum_nx;
                r_fill    <= w_fill_nx;
                r_slot    <= (w_slot_inc >= (CNT_W+1)'(w_n)) ? '0 : WIN_AW'(w_slot_inc);
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.err_position   = r_out.err_position;
    assign o_out.err_velocity   = r_out.err_velocity;
    assign o_out.err_pitch      = r_out.err_pitch;
    assign o_out.err_pitch_rate = r_out.err_pitch_rate;
    assign o_out.err_yaw        = r_out.err_yaw;
    assign o_out.err_yaw_rate   = r_out.err_yaw_rate;
endmodule
`default_nettype wire

// File: hw/rtl/moving_average_state_error.sv
`default_nettype none
// Command writes are done in the idle state. An IMU item below the saturation
// bound runs seven Horner steps of the arcsine polynomial and a 31-step square
// root. An odometry item runs a window memory read and a bit-serial divider of
// SUM_W steps before its result. Items run one at a time.
// Reset is synchronous and clears targets, flags, sums and the fill count.
// ----------------------------------------------------------------------------
// moving_average_state_error
// Balance error vector with moving-average velocity filters, APB window size.
// ----------------------------------------------------------------------------
module moving_average_state_error import mase_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    mase_in_if.sink                i_in,
    mase_out_if.source             o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    logic       w_wsize;
    logic [7:0] r_window_size;
    logic       w_q_valid;
    t_item      w_q_item;
    logic       w_q_pop;
    t_cfg       w_cfg;

    assign pready  = 1'b1;
    assign w_wsize = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);
    assign prdata  = (paddr[2] == REG_WINDOW_SIZE) ? {24'd0, r_window_size} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_RESET;
        end else if (w_wsize) begin
            r_window_size <= pwdata[7:0];
        end
    end

    assign w_cfg.wr   = w_wsize;
    assign w_cfg.size = r_window_size;

    mase_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_q_valid(w_q_valid),
        .o_q_item (w_q_item),
        .i_q_pop  (w_q_pop)
    );

    mase_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(w_q_valid),
        .i_q_item (w_q_item),
        .o_q_pop  (w_q_pop),
        .i_cfg    (w_cfg),
        .o_out    (o_out)
    );

`ifndef SYNTH
    a_q_no_idle_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_valid |-> (w_q_item.action != ACT_NONE))
        else $error("Queue holds an item without effect.");
    a_q_cmd_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_valid && (w_q_item.action == ACT_CMD)) |-> (w_q_item.cmd_index < 3'd6))
        else $error("Queue holds a command write to a bad target slot.");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("Queue popped while empty.");
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wsize |=> (r_window_size == $past(pwdata[7:0])))
        else $error("Window size write not taken.");
`endif
endmodule
`default_nettype wire

// File: tb/tb_moving_average_state_error.sv
// ----------------------------------------------------------------------------
// tb_moving_average_state_error
// Self-checking bench for the balance error block: directed and random events,
// window size changes over APB, random idling on both channels, and a
// scoreboard that predicts each error vector and compares it field by field.
// ----------------------------------------------------------------------------
module tb_moving_average_state_error;
    import mase_pkg::*;

    localparam int       LIMIT      = 400000;
    localparam int       TAIL       = 120;
    localparam int       ITEM_W     = $bits(t_item);
    localparam logic [2:0] ADDR_WINDOW = 3'd0;
    localparam logic [2:0] ADDR_SPARE  = 3'd4;

    class balance_scoreboard;
        logic signed [31:0] targets [NUM_TARGETS];
        bit                 have_target;
        bit                 have_attitude;
        logic signed [31:0] pitch_q16;
        logic signed [31:0] pitch_rate_q16;
        logic signed [31:0] vel_hist [WINDOW_MAX];
        logic signed [31:0] yaw_hist [WINDOW_MAX];
        longint             vel_total;
        longint             yaw_total;
        int unsigned        fill;
        int unsigned        slot_ptr;
        logic [7:0]         win_reg;
        t_result            pending [$];
        int                 errors;

        function new();
            errors = 0;
            win_reg = WINDOW_RESET;
            have_target = 0;
            have_attitude = 0;
            pitch_q16 = 0;
            pitch_rate_q16 = 0;
            foreach (targets[i]) targets[i] = 0;
            clear_filters();
        endfunction

        function void clear_filters();
            vel_total = 0;
            yaw_total = 0;
            fill = 0;
            slot_ptr = 0;
        endfunction

        function void set_window(logic [7:0] v);
            win_reg = v;
            clear_filters();
        endfunction

        function longint round_q30(longint a, longint b);
            longint p;
            p = a * b + (64'sd1 <<< 29);
            return p >>> 30;
        endfunction

        function longint int_sqrt(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function logic signed [31:0] pitch_from_quat(longint w, longint x, longint y, longint z);
            longint s, mag, x30, p, sq, r30, q16;
            s = 2 * (w * y - z * x);
            mag = (s < 0) ? -s : s;
            if (mag >= longint'(ONE_Q28)) return (s < 0) ? -HALF_PI_Q16 : HALF_PI_Q16;
            x30 = mag * 4;
            p = ASIN_COEF[7];
            for (int k = 6; k >= 0; k--) p = longint'(ASIN_COEF[k]) + round_q30(p, x30);
            sq = int_sqrt(longint'(longint'(ONE_Q30) - x30) << 30);
            r30 = longint'(HALF_PI_Q30) - round_q30(sq, p);
            if (r30 < 0) r30 = 0;
            q16 = (r30 + 8192) >>> 14;
            return (s < 0) ? -q16 : q16;
        endfunction

        function logic signed [31:0] clip32(longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function longint mean_rounded(longint sum, int unsigned n);
            longint mag, q;
            mag = (sum < 0) ? -sum : sum;
            q = (mag + n / 2) / n;
            return (sum < 0) ? -q : q;
        endfunction

        function void note_item(t_item it);
            int unsigned n, s;
            t_result r;
            case (it.action)
                ACT_CMD: begin
                    if (it.cmd_index < NUM_TARGETS) begin
                        targets[it.cmd_index] = it.cmd_value;
                        have_target = 1;
                    end
                end
                ACT_IMU: begin
                    pitch_q16 = pitch_from_quat(it.quat_w, it.quat_x, it.quat_y, it.quat_z);
                    pitch_rate_q16 = it.pitch_rate;
                    have_attitude = 1;
                end
                ACT_ODO: begin
                    if (have_target && have_attitude) begin
                        n = (win_reg == 0) ? 1 : ((win_reg > WINDOW_MAX) ? WINDOW_MAX : win_reg);
                        s = (slot_ptr >= n) ? 0 : slot_ptr;
                        if (fill >= n) begin
                            vel_total -= vel_hist[s];
                            yaw_total -= yaw_hist[s];
                            fill = n;
                        end else begin
                            fill++;
                        end
                        vel_hist[s] = it.lin_vel;
                        yaw_hist[s] = it.yaw_vel;
                        vel_total += it.lin_vel;
                        yaw_total += it.yaw_vel;
                        s++;
                        slot_ptr = (s >= n) ? 0 : s;
                        r.err_position   = clip32(longint'(targets[TGT_POSITION]) - it.position);
                        r.err_velocity   = clip32(longint'(targets[TGT_VELOCITY])
                                                  - mean_rounded(vel_total, fill));
                        r.err_pitch      = clip32(longint'(targets[TGT_PITCH]) - pitch_q16);
                        r.err_pitch_rate = clip32(longint'(targets[TGT_PITCH_RATE])
                                                  - pitch_rate_q16);
                        r.err_yaw        = targets[TGT_YAW];
                        r.err_yaw_rate   = clip32(longint'(targets[TGT_YAW_RATE])
                                                  - mean_rounded(yaw_total, fill));
                        pending.insert(pending.size(), r);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (pending.size() == 0) begin
                $error("unexpected result item %h", got);
                errors++;
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (got.err_position !== e.err_position) begin
                $error("err_position expected %0d actual %0d", e.err_position, got.err_position);
                errors++;
            end
            if (got.err_velocity !== e.err_velocity) begin
                $error("err_velocity expected %0d actual %0d", e.err_velocity, got.err_velocity);
                errors++;
            end
            if (got.err_pitch !== e.err_pitch) begin
                $error("err_pitch expected %0d actual %0d", e.err_pitch, got.err_pitch);
                errors++;
            end
            if (got.err_pitch_rate !== e.err_pitch_rate) begin
                $error("err_pitch_rate expected %0d actual %0d",
                       e.err_pitch_rate, got.err_pitch_rate);
                errors++;
            end
            if (got.err_yaw !== e.err_yaw) begin
                $error("err_yaw expected %0d actual %0d", e.err_yaw, got.err_yaw);
                errors++;
            end
            if (got.err_yaw_rate !== e.err_yaw_rate) begin
                $error("err_yaw_rate expected %0d actual %0d", e.err_yaw_rate, got.err_yaw_rate);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          cycles;

    mase_in_if  in_ch ();
    mase_out_if out_ch ();
    balance_scoreboard board;

    moving_average_state_error dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            board.check_result({out_ch.err_position, out_ch.err_velocity, out_ch.err_pitch,
                                out_ch.err_pitch_rate, out_ch.err_yaw, out_ch.err_yaw_rate});
        end
    end

    always @(negedge i_clk) begin
        if (recv_idle_pct > 0) begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic send_item(t_item it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= it.action;
        in_ch.cmd_index  <= it.cmd_index;
        in_ch.cmd_value  <= it.cmd_value;
        in_ch.quat_w     <= it.quat_w;
        in_ch.quat_x     <= it.quat_x;
        in_ch.quat_y     <= it.quat_y;
        in_ch.quat_z     <= it.quat_z;
        in_ch.pitch_rate <= it.pitch_rate;
        in_ch.position   <= it.position;
        in_ch.lin_vel    <= it.lin_vel;
        in_ch.yaw_vel    <= it.yaw_vel;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_WINDOW) board.set_window(data[7:0]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (TAIL) @(negedge i_clk);
    endtask

    function automatic t_item random_item();
        t_item it;
        int    pick;
        it = t_item'(ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom}));
        pick = $urandom_range(99);
        if (pick < 15) begin
            it.action = ACT_CMD;
            it.cmd_index = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                                     : 3'($urandom_range(5));
            if ($urandom_range(1)) it.cmd_value = $signed(32'($urandom_range(400000)))
                                                  - 32'sd200000;
        end else if (pick < 30) begin
            it.action = ACT_IMU;
            if ($urandom_range(3) != 0) begin
                it.quat_w = 16'($urandom_range(32768)) - 16'sd16384;
                it.quat_x = 16'($urandom_range(32768)) - 16'sd16384;
                it.quat_y = 16'($urandom_range(32768)) - 16'sd16384;
                it.quat_z = 16'($urandom_range(32768)) - 16'sd16384;
                if ($urandom_range(1)) begin
                    it.quat_w = it.quat_w >>> 2;
                    it.quat_z = it.quat_z >>> 2;
                end
            end
        end else if (pick < 95) begin
            it.action = ACT_ODO;
        end else begin
            it.action = ACT_NONE;
        end
        return it;
    endfunction

    task automatic random_phase(int count, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count) send_item(random_item());
    endtask

    initial begin
        t_item it;
        board = new();
        cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_NONE;
        in_ch.cmd_index = '0;
        in_ch.cmd_value = '0;
        in_ch.quat_w = '0;
        in_ch.quat_x = '0;
        in_ch.quat_y = '0;
        in_ch.quat_z = '0;
        in_ch.pitch_rate = '0;
        in_ch.position = '0;
        in_ch.lin_vel = '0;
        in_ch.yaw_vel = '0;
        out_ch.ready = 1'b1;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: odometry before the block is armed, unused action, bad slots.
        it = '0;
        it.action = ACT_ODO;
        it.lin_vel = 32'sh7fffffff;
        send_item(it);
        it.action = ACT_NONE;
        send_item(it);
        it = '0;
        it.action = ACT_CMD;
        it.cmd_index = 3'd6;
        it.cmd_value = 32'sh80000000;
        send_item(it);
        it.cmd_index = 3'd7;
        send_item(it);
        it.action = ACT_ODO;
        send_item(it);
        for (int i = 0; i < NUM_TARGETS; i++) begin
            it = '0;
            it.action = ACT_CMD;
            it.cmd_index = 3'(i);
            it.cmd_value = (i % 2) ? 32'sh7fffffff : 32'sh80000000;
            send_item(it);
        end
        it = '0;
        it.action = ACT_IMU;
        it.quat_w = 16'sd16384;
        it.quat_y = 16'sd16384;
        it.pitch_rate = 32'sh80000000;
        send_item(it);
        it.action = ACT_ODO;
        it.position = 32'sh7fffffff;
        it.lin_vel = 32'sh80000000;
        it.yaw_vel = 32'sh80000000;
        send_item(it);
        it.position = 32'sh80000000;
        it.lin_vel = 32'sh7fffffff;
        it.yaw_vel = 32'sh7fffffff;
        send_item(it);
        it = '0;
        it.action = ACT_IMU;
        it.quat_w = 16'sh8000;
        it.quat_x = 16'sh7fff;
        it.quat_y = 16'sh7fff;
        it.quat_z = 16'sh8000;
        it.pitch_rate = 32'sh7fffffff;
        send_item(it);
        it.quat_w = 16'sd11585;
        it.quat_x = 16'sd0;
        it.quat_y = -16'sd4000;
        it.quat_z = 16'sd3000;
        send_item(it);
        it = '1;
        it.action = ACT_ODO;
        send_item(it);
        drain();

        write_reg(ADDR_WINDOW, 32'd1);
        write_reg(ADDR_SPARE, 32'hffffffff);
        random_phase(60, 26, 82);
        drain();
        write_reg(ADDR_WINDOW, 32'd0);
        random_phase(40, 26, 82);
        drain();
        write_reg(ADDR_WINDOW, 32'd255);
        random_phase(170, 82, 26);
        drain();
        write_reg(ADDR_WINDOW, 32'd128);
        random_phase(60, 0, 0);
        drain();
        write_reg(ADDR_WINDOW, 32'($urandom_range(2, 20)));
        random_phase(170, 0, 0);
        drain();

        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// File: moving_average_state_error.f
hw/rtl/mase_pkg.sv
hw/rtl/mase_if.sv
hw/rtl/mase_ram.sv
hw/rtl/mase_front.sv
hw/rtl/mase_back.sv
hw/rtl/moving_average_state_error.sv
tb/tb_moving_average_state_error.sv
